/* sv/uxs_pkg.sv */
// Shared types, constants and helper functions of the UTF-8 XML text sanitizer.
package uxs_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_APOS  = 8'h27;

   typedef enum logic [2:0] {
      ENT_NONE,
      ENT_AMP,
      ENT_LT,
      ENT_GT,
      ENT_QUOT,
      ENT_APOS
   } ent_type;

   // One queued item: '?' run, literal bytes or an entity, trailing '?' run.
   typedef struct packed {
      logic [1:0]      pre_q;
      logic [3:0][7:0] body;
      logic [2:0]      body_n;
      ent_type         ent;
      logic [1:0]      post_q;
      logic            last;
   } job_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] ch;
      ent_type    ent;
      logic       open;
      logic [2:0] len;
   } fresh_type;

   // Classify a byte seen with no sequence open.
   function automatic fresh_type fresh_classify(input logic [7:0] b, input logic esc);
      fresh_type f;
      f = '{emit: 1'b0, ch: b, ent: ENT_NONE, open: 1'b0, len: 3'd0};
      if (b < CHAR_SPACE) begin
         f.emit = (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
      end else if (b == CHAR_DEL) begin
         f.emit = 1'b0;
      end else if (b < 8'h80) begin
         if (esc && b == CHAR_AMP) begin
            f.ent = ENT_AMP;
         end else if (esc && b == CHAR_LT) begin
            f.ent = ENT_LT;
         end else if (esc && b == CHAR_GT) begin
            f.ent = ENT_GT;
         end else if (esc && b == CHAR_QUOT) begin
            f.ent = ENT_QUOT;
         end else if (esc && b == CHAR_APOS) begin
            f.ent = ENT_APOS;
         end else begin
            f.emit = 1'b1;
         end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         f.open = 1'b1;
         f.len  = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         f.open = 1'b1;
         f.len  = 3'd3;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         f.open = 1'b1;
         f.len  = 3'd4;
      end else begin
         f.emit = 1'b1;
         f.ch   = CHAR_QMARK;
      end
      return f;
   endfunction

   function automatic logic [2:0] ent_len(input ent_type e);
      logic [2:0] n;
      unique case (e)
         ENT_AMP:  n = 3'd5;
         ENT_LT:   n = 3'd4;
         ENT_GT:   n = 3'd4;
         ENT_QUOT: n = 3'd6;
         ENT_APOS: n = 3'd6;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ent_char(input ent_type e, input logic [2:0] i);
      logic [7:0] c;
      c = 8'h3B; // ';' closes every entity
      if (i == 3'd0) begin
         c = CHAR_AMP;
      end else begin
         unique case (e)
            ENT_AMP: begin
               case (i)
                  3'd1:    c = 8'h61; // a
                  3'd2:    c = 8'h6D; // m
                  3'd3:    c = 8'h70; // p
                  default: c = 8'h3B;
               endcase
            end
            ENT_LT: begin
               case (i)
                  3'd1:    c = 8'h6C; // l
                  3'd2:    c = 8'h74; // t
                  default: c = 8'h3B;
               endcase
            end
            ENT_GT: begin
               case (i)
                  3'd1:    c = 8'h67; // g
                  3'd2:    c = 8'h74; // t
                  default: c = 8'h3B;
               endcase
            end
            ENT_QUOT: begin
               case (i)
                  3'd1:    c = 8'h71; // q
                  3'd2:    c = 8'h75; // u
                  3'd3:    c = 8'h6F; // o
                  3'd4:    c = 8'h74; // t
                  default: c = 8'h3B;
               endcase
            end
            ENT_APOS: begin
               case (i)
                  3'd1:    c = 8'h61; // a
                  3'd2:    c = 8'h70; // p
                  3'd3:    c = 8'h6F; // o
                  3'd4:    c = 8'h73; // s
                  default: c = 8'h3B;
               endcase
            end
            default: c = 8'h3B;
         endcase
      end
      return c;
   endfunction

endpackage

/* sv/uxs_front.sv */
// Front end: UTF-8 sequence tracking and classification of each input byte into a job.
module uxs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last,
   input  logic              escape_enable,
   output uxs_pkg::job_type  job,
   output logic              job_push
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      count_ff, count_in;
   logic [2:0]      seq_len_ff, seq_len_in;

   uxs_pkg::fresh_type fr;
   logic               ok;
   logic [2:0]         k_ext;

   always_comb begin
      fr    = uxs_pkg::fresh_classify(data_byte, escape_enable);
      k_ext = {1'b0, count_ff};

      ok = (data_byte[7:6] == 2'b10) && (count_ff != 2'd0) && (k_ext < seq_len_ff);
      if (count_ff == 2'd1) begin
         if (held_ff[0] == 8'hE0 && data_byte < 8'hA0) ok = 1'b0;
         if (held_ff[0] == 8'hED && data_byte >= 8'hA0) ok = 1'b0;
         if (held_ff[0] == 8'hF0 && data_byte < 8'h90) ok = 1'b0;
         if (held_ff[0] == 8'hF4 && data_byte >= 8'h90) ok = 1'b0;
      end

      job        = '0;
      job.ent    = uxs_pkg::ENT_NONE;
      job.last   = last;
      held_in    = held_ff;
      count_in   = count_ff;
      seq_len_in = seq_len_ff;

      if (count_ff == 2'd0 || !ok) begin
         // rejected held bytes (if any) turn to '?', then the byte starts over
         job.pre_q   = count_ff;
         job.body[0] = fr.ch;
         job.body_n  = fr.emit ? 3'd1 : 3'd0;
         job.ent     = fr.ent;
         if (fr.open) begin
            held_in[0] = data_byte;
            count_in   = 2'd1;
            seq_len_in = fr.len;
         end else begin
            count_in   = 2'd0;
            seq_len_in = 3'd0;
         end
      end else if (k_ext + 3'd1 == seq_len_ff) begin
         // sequence complete: release held bytes plus this one
         for (int j = 0; j < 4; j++) begin
            if (j < 3 && 2'(j) < count_ff) begin
               job.body[j] = held_ff[j];
            end else begin
               job.body[j] = data_byte;
            end
         end
         job.body_n = k_ext + 3'd1;
         count_in   = 2'd0;
         seq_len_in = 3'd0;
      end else begin
         held_in[count_ff] = data_byte;
         count_in          = count_ff + 2'd1;
      end

      // end of text flushes whatever is still open
      if (last && count_in != 2'd0) begin
         job.post_q = count_in;
         count_in   = 2'd0;
         seq_len_in = 3'd0;
      end

      job_push = (job.pre_q != 2'd0) || (job.body_n != 3'd0) ||
                 (job.ent != uxs_pkg::ENT_NONE) || (job.post_q != 2'd0) || last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 2'd0;
         seq_len_ff <= 3'd0;
      end else if (accept) begin
         count_ff   <= count_in;
         seq_len_ff <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

/* sv/uxs_queue.sv */
// Small job queue between the front end and the output serializer.
module uxs_queue #(
   parameter int DEPTH = uxs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  uxs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output uxs_pkg::job_type head_job,
   output logic             head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   uxs_pkg::job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* sv/uxs_back.sv */
// Back end: writes a queued job's bytes to the output register, one per cycle unless stalled.
module uxs_back (
   input  logic             clock,
   input  logic             reset,
   input  uxs_pkg::job_type head_job,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_end_of_text
);

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       has_ff;
   logic       eot_ff;

   logic [3:0] body_end, ent_end, total;
   logic [3:0] body_off, ent_off;
   logic [7:0] sym;
   logic       final_sym;
   logic       load;

   always_comb begin
      body_end = {2'b00, head_job.pre_q} + {1'b0, head_job.body_n};
      ent_end  = body_end + {1'b0, uxs_pkg::ent_len(head_job.ent)};
      total    = ent_end + {2'b00, head_job.post_q};
      body_off = idx_ff - {2'b00, head_job.pre_q};
      ent_off  = idx_ff - body_end;

      if (idx_ff < {2'b00, head_job.pre_q}) begin
         sym = uxs_pkg::CHAR_QMARK;
      end else if (idx_ff < body_end) begin
         sym = head_job.body[body_off[1:0]];
      end else if (idx_ff < ent_end) begin
         sym = uxs_pkg::ent_char(head_job.ent, ent_off[2:0]);
      end else begin
         sym = uxs_pkg::CHAR_QMARK;
      end

      final_sym = (total == 4'd0) || (idx_ff == total - 4'd1);
      load      = head_valid && (!valid_ff || !rsp_stall);
      pop       = load && final_sym;

      idx_in = idx_ff;
      if (load) begin
         idx_in = final_sym ? 4'd0 : idx_ff + 4'd1;
      end

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= (total == 4'd0) ? 8'h00 : sym;
         has_ff  <= (total != 4'd0);
         eot_ff  <= final_sym && head_job.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_has_byte    = has_ff;
   assign rsp_end_of_text = eot_ff;

endmodule

/* sv/utf8_xml_text_sanitizer.sv */
// Top level of the UTF-8 validating XML text sanitizer.
//
// Takes one text byte per transfer on the req_ channel and produces clean XML text
// on the rsp_ channel, one output byte per transfer. C0 controls other than tab,
// LF and CR are dropped, as is DEL. Multi-byte UTF-8 sequences are held until
// complete and well formed (no overlongs, surrogates or code points above
// U+10FFFF); a broken sequence turns each held byte into '?' and the breaking
// byte is looked at again. With escape_enable set (reset value 1), & < > " '
// go out as XML entities. A byte flagged req_last closes the text: an open
// sequence is flushed as '?' bytes and the last output transfer carries
// rsp_end_of_text; if that byte produced no text, one transfer with
// rsp_has_byte low carries the end marker alone. Rate: one input byte per
// cycle unless the queue is full. Output runs at one byte per cycle unless
// rsp_stall is high, so an input byte that expands to N output bytes (an
// entity of 4 to 6 bytes, a released sequence of up to 4, '?' runs) occupies
// the output serializer for N transfers; a queue of QUEUE_DEPTH classified
// items sits between the front end and the serializer, and req_stall rises
// only when that queue is full. Output bytes leave from a register. The
// escape_enable register is written on the csr_ channel (always ready) and
// is meant to change only while the block is idle.
module utf8_xml_text_sanitizer #(
   parameter int QUEUE_DEPTH = uxs_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,

   // input text bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,

   // output text bytes
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_end_of_text,

   // escape_enable register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_escape_enable
);

   logic             escape_enable_ff;
   logic             req_accept;
   logic             queue_full;
   logic             job_push;
   logic             job_pop;
   logic             head_valid;
   uxs_pkg::job_type front_job;
   uxs_pkg::job_type head_job;

   // the queue's fill state alone decides whether a new byte can be taken
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         escape_enable_ff <= csr_escape_enable;
      end
   end

   // classify the byte and update the open-sequence state
   uxs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_data_byte),
      .last          (req_last),
      .escape_enable (escape_enable_ff),
      .job           (front_job),
      .job_push      (job_push)
   );

   // items that emit nothing and do not close the text never enter the queue
   uxs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept && job_push),
      .push_job   (front_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   // expand each job into output bytes, one transfer at a time
   uxs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_valid      (head_valid),
      .pop             (job_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule

/* bench/utf8_xml_text_sanitizer_tb.sv */
// Self-checking bench for utf8_xml_text_sanitizer: byte stimulus, predicted XML text, scoreboard.
`timescale 1ns / 1ps

// One output transfer as seen on the rsp_ channel.
typedef struct packed {
   logic [7:0] out_byte;
   logic       has_byte;
   logic       end_of_text;
} text_beat_type;

// Predicts the sanitized text for each accepted input byte and checks the
// output transfers against it in order.
class xml_text_scoreboard;
   text_beat_type pending_text[$];   // predicted transfers not yet seen
   text_beat_type byte_text[$];      // transfers caused by the byte in hand
   logic [7:0]    held[3];           // lead and continuation bytes of the open sequence
   logic [1:0]    held_n;
   logic [2:0]    seq_len;
   bit            escape_on;
   int unsigned   errors;

   function new();
      held_n    = '0;
      seq_len   = '0;
      escape_on = 1'b1;
      errors    = 0;
      foreach (held[i]) held[i] = '0;
   endfunction

   function void emit(logic [7:0] c);
      text_beat_type t;
      t.out_byte    = c;
      t.has_byte    = 1'b1;
      t.end_of_text = 1'b0;
      byte_text.insert(byte_text.size(), t);
   endfunction

   function void emit_entity(string s);
      for (int i = 0; i < s.len(); i++) emit(s[i]);
   endfunction

   // Plain ASCII text; markup turns into an entity when escaping is on.
   function void emit_text(logic [7:0] c);
      if (!escape_on) begin
         emit(c);
         return;
      end
      case (c)
         uxs_pkg::CHAR_AMP:  emit_entity("&amp;");
         uxs_pkg::CHAR_LT:   emit_entity("&lt;");
         uxs_pkg::CHAR_GT:   emit_entity("&gt;");
         uxs_pkg::CHAR_QUOT: emit_entity("&quot;");
         uxs_pkg::CHAR_APOS: emit_entity("&apos;");
         default:            emit(c);
      endcase
   endfunction

   function void clear_sequence();
      held_n  = '0;
      seq_len = '0;
      foreach (held[i]) held[i] = '0;
   endfunction

   function void open_sequence(logic [7:0] c, logic [2:0] n);
      held[0] = c;
      held_n  = 2'd1;
      seq_len = n;
   endfunction

   // A byte looked at with no sequence open.
   function void take_fresh(logic [7:0] c);
      if (c < uxs_pkg::CHAR_SPACE) begin
         if (c == uxs_pkg::CHAR_TAB || c == uxs_pkg::CHAR_LF || c == uxs_pkg::CHAR_CR) emit(c);
      end else if (c == uxs_pkg::CHAR_DEL) begin
         // dropped
      end else if (c < 8'h80) begin
         emit_text(c);
      end else if (c >= 8'hC2 && c <= 8'hDF) begin
         open_sequence(c, 3'd2);
      end else if (c[7:4] == 4'hE) begin
         open_sequence(c, 3'd3);
      end else if (c >= 8'hF0 && c <= 8'hF4) begin
         open_sequence(c, 3'd4);
      end else begin
         emit(uxs_pkg::CHAR_QMARK);   // invalid lead or stray continuation
      end
   endfunction

   function void reject_held();
      for (int i = 0; i < held_n; i++) emit(uxs_pkg::CHAR_QMARK);
      clear_sequence();
   endfunction

   // A byte that arrives while a sequence is open.
   function void take_follow(logic [7:0] c);
      logic ok;
      ok = (c[7:6] == 2'b10) && (held_n < seq_len);
      if (ok && held_n == 2'd1) begin
         // second-byte limits: overlongs, surrogates, above U+10FFFF
         if (held[0] == 8'hE0 && c <  8'hA0) ok = 1'b0;
         if (held[0] == 8'hED && c >= 8'hA0) ok = 1'b0;
         if (held[0] == 8'hF0 && c <  8'h90) ok = 1'b0;
         if (held[0] == 8'hF4 && c >= 8'h90) ok = 1'b0;
      end
      if (!ok) begin
         reject_held();
         take_fresh(c);
         return;
      end
      if (held_n + 1 == seq_len) begin
         for (int i = 0; i < held_n; i++) emit(held[i]);
         emit(c);
         clear_sequence();
      end else begin
         held[held_n] = c;
         held_n       = held_n + 2'd1;
      end
   endfunction

   function void note_input(logic [7:0] c, logic fin);
      text_beat_type closing;
      byte_text.delete();
      if (held_n != 0) take_follow(c);
      else take_fresh(c);
      if (fin) begin
         if (held_n != 0) reject_held();
         if (byte_text.size() == 0) begin
            closing.out_byte    = 8'h00;
            closing.has_byte    = 1'b0;
            closing.end_of_text = 1'b1;
            byte_text.insert(byte_text.size(), closing);
         end else begin
            byte_text[byte_text.size() - 1].end_of_text = 1'b1;
         end
      end
      foreach (byte_text[i]) pending_text.insert(pending_text.size(), byte_text[i]);
   endfunction

   function void check_result(logic [7:0] ob, logic hb, logic eot);
      text_beat_type want;
      if (pending_text.size() == 0) begin
         errors++;
         $display("%0t: expected no transfer, actual out_byte=%02h has_byte=%0b end_of_text=%0b",
                  $time, ob, hb, eot);
         return;
      end
      want = pending_text.pop_front();
      if (want.out_byte !== ob) begin
         errors++;
         $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, ob);
      end
      if (want.has_byte !== hb) begin
         errors++;
         $display("%0t: has_byte expected %0b actual %0b", $time, want.has_byte, hb);
      end
      if (want.end_of_text !== eot) begin
         errors++;
         $display("%0t: end_of_text expected %0b actual %0b", $time, want.end_of_text, eot);
      end
   endfunction
endclass

module utf8_xml_text_sanitizer_tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last      = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_end_of_text;

   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   logic       csr_escape_enable = 1'b0;

   // When set, neither side idles: one long stretch of back-to-back transfers.
   bit         quiet = 1'b0;

   xml_text_scoreboard sb;

   // Bytes of one random text fragment, built before it is sent.
   logic [7:0] fragment[$];

   utf8_xml_text_sanitizer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_end_of_text   (rsp_end_of_text),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_escape_enable (csr_escape_enable)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver backpressure: stall with a chance of 28 in 100 unless in the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 28);
   end

   // Monitor. Everything the bench drives changes by nonblocking assignment at the
   // edge, so values read here are the ones the block sampled at this edge.
   // The input is noted first; it enters the queue and its output is registered
   // after that, so a transfer at this edge can never be one of its results anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_data_byte, req_last);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_out_byte, rsp_has_byte,
                                                      rsp_end_of_text);
      end
   end

   // One input transfer, with a random idle gap in front of it. Valid stays high
   // from one byte to the next when there is no gap, so each step sees at most
   // one assignment to req_valid.
   task automatic send_byte(logic [7:0] c, logic fin);
      while (!quiet && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= c;
      req_last      <= fin;
      do @(posedge clock); while (req_stall);
   endtask

   // Sender holds off until every predicted transfer has come back, then keeps
   // waiting for anything still in flight that makes no output (dropped
   // controls, held sequence bytes). The first edge lets the monitor note the
   // final input before the count is looked at.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_text.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_escape(logic v);
      csr_valid         <= 1'b1;
      csr_escape_enable <= v;
      do @(posedge clock); while (!csr_ready);
      sb.escape_on = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(8'hBF, 8'h80));
   endfunction

   // Appends one well-formed multi-byte character, leaning on the leads whose
   // second byte has a narrowed range.
   function automatic void push_code_point();
      logic [7:0] lead;
      case ($urandom_range(4, 2))
         2: begin
            fragment.insert(fragment.size(), 8'($urandom_range(8'hDF, 8'hC2)));
            fragment.insert(fragment.size(), any_cont());
         end
         3: begin
            case ($urandom_range(3))
               0:       lead = 8'hE0;
               1:       lead = 8'hED;
               default: lead = 8'($urandom_range(8'hEF, 8'hE0));
            endcase
            fragment.insert(fragment.size(), lead);
            if (lead == 8'hE0)
               fragment.insert(fragment.size(), 8'($urandom_range(8'hBF, 8'hA0)));
            else if (lead == 8'hED)
               fragment.insert(fragment.size(), 8'($urandom_range(8'h9F, 8'h80)));
            else
               fragment.insert(fragment.size(), any_cont());
            fragment.insert(fragment.size(), any_cont());
         end
         default: begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            fragment.insert(fragment.size(), lead);
            if (lead == 8'hF0)
               fragment.insert(fragment.size(), 8'($urandom_range(8'hBF, 8'h90)));
            else if (lead == 8'hF4)
               fragment.insert(fragment.size(), 8'($urandom_range(8'h8F, 8'h80)));
            else
               fragment.insert(fragment.size(), any_cont());
            fragment.insert(fragment.size(), any_cont());
            fragment.insert(fragment.size(), any_cont());
         end
      endcase
   endfunction

   // Mostly well-formed text: characters, ASCII with plenty of markup, controls.
   // The rest is truncated sequences, suspect second bytes and raw noise.
   function automatic void build_fragment();
      int unsigned sel;
      int unsigned keep;
      fragment.delete();
      sel = $urandom_range(99);
      if (sel < 40) begin
         push_code_point();
      end else if (sel < 62) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(4))
               0:       fragment.insert(fragment.size(), uxs_pkg::CHAR_AMP);
               1:       fragment.insert(fragment.size(), uxs_pkg::CHAR_LT);
               2:       fragment.insert(fragment.size(), uxs_pkg::CHAR_GT);
               3:       fragment.insert(fragment.size(), uxs_pkg::CHAR_QUOT);
               default: fragment.insert(fragment.size(), uxs_pkg::CHAR_APOS);
            endcase
         end else begin
            fragment.insert(fragment.size(), 8'($urandom_range(8'h7E, 8'h20)));
         end
      end else if (sel < 70) begin
         if ($urandom_range(7) == 0)
            fragment.insert(fragment.size(), uxs_pkg::CHAR_DEL);
         else
            fragment.insert(fragment.size(), 8'($urandom_range(8'h1F, 8'h00)));
      end else if (sel < 85) begin
         // cut a character short and follow it with anything
         push_code_point();
         keep = $urandom_range(fragment.size() - 1, 1);
         while (fragment.size() > keep) void'(fragment.pop_back());
         fragment.insert(fragment.size(), 8'($urandom_range(8'hFF, 8'h00)));
      end else if (sel < 90) begin
         // narrowed lead with an unconstrained second byte: often rejected
         case ($urandom_range(3))
            0:       fragment.insert(fragment.size(), 8'hE0);
            1:       fragment.insert(fragment.size(), 8'hED);
            2:       fragment.insert(fragment.size(), 8'hF0);
            default: fragment.insert(fragment.size(), 8'hF4);
         endcase
         fragment.insert(fragment.size(), any_cont());
      end else begin
         fragment.insert(fragment.size(), 8'($urandom_range(8'hFF, 8'h00)));
      end
   endfunction

   // Random text; last is set now and then, and always on the closing byte.
   task automatic send_random_text(int unsigned count);
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         build_fragment();
         foreach (fragment[i]) begin
            send_byte(fragment[i], $urandom_range(99) < 4);
            sent++;
         end
      end
      send_byte(8'($urandom_range(8'hFF, 8'h00)), 1'b1);
   endtask

   // Directed opener, escaping on (reset value): controls kept and dropped, every
   // markup character, the largest legal code point, each rejected second byte,
   // the top invalid lead, a sequence broken by ASCII, a sequence cut off by
   // last, and a last byte that makes no text.
   task automatic send_opening_text();
      logic [7:0] opening[$];
      opening = '{8'h00, uxs_pkg::CHAR_TAB, uxs_pkg::CHAR_CR, uxs_pkg::CHAR_DEL,
                  uxs_pkg::CHAR_AMP, uxs_pkg::CHAR_LT, uxs_pkg::CHAR_GT,
                  uxs_pkg::CHAR_QUOT, uxs_pkg::CHAR_APOS,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF,
                  8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
                  8'hFF, 8'hE2, 8'h41, 8'hE2};
      foreach (opening[i]) send_byte(opening[i], 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'h01, 1'b1);
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_opening_text();
      settle();

      write_escape(1'b0);
      send_random_text(100);
      settle();

      // Escaping back on, no idling on either side for this stretch.
      write_escape(1'b1);
      quiet = 1'b1;
      send_random_text(100);
      settle();
      quiet = 1'b0;

      write_escape(1'b0);
      send_random_text(100);
      settle();

      if (sb.errors == 0 && sb.pending_text.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/uxs_pkg.sv
sv/uxs_front.sv
sv/uxs_queue.sv
sv/uxs_back.sv
sv/utf8_xml_text_sanitizer.sv
bench/utf8_xml_text_sanitizer_tb.sv
